@@ rtl/rrqs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants for the round-robin quantum scheduler: item
// layouts, command and status codes, and the saturating time increment.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  // input item: load a task slot or advance one tick
  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic [7:0]  task_id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } rrqs_in_t;

  // result item: one per tick
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  running_id;
    logic        completed;
    logic [15:0] finish_tick;
  } rrqs_out_t;

  // ready queue status seen by the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } rrqs_qstat_t;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RAN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [15:0] QUANTUM_RST = 16'd2;
  localparam logic [15:0] TIME_MAX    = 16'hFFFF;

  // increment that sticks at the top of the 16-bit range
  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == TIME_MAX) ? v : v + 16'd1;
  endfunction

endpackage

@@ rtl/rrqs_ready_fifo.sv @@
// ----------------------------------------------------------------------------
// rrqs_ready_fifo
// FIFO ready queue of slot numbers. A push to a full queue is dropped unless
// a pop happens in the same cycle. The head entry is read into a register
// every cycle.
// ----------------------------------------------------------------------------
module rrqs_ready_fifo #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [IW-1:0]         push_data,
  input  logic                  pop,
  output logic [IW-1:0]         head_data,
  output rrqs_pkg::rrqs_qstat_t stat
);
  import rrqs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [IW-1:0] mem [DEPTH];
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] head_data_r;
  logic          do_push, do_pop;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
  endfunction

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

  assign do_pop  = pop && !stat.empty;
  assign do_push = push && (!stat.full || do_pop);

  // pointer and count update
  always_comb begin
    head_nxt  = do_pop  ? ptr_inc(head_r) : head_r;
    tail_nxt  = do_push ? ptr_inc(tail_r) : tail_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // storage: one write at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= push_data;
    end
    head_data_r <= mem[head_r];
  end

  assign head_data = head_data_r;

endmodule

@@ rtl/round_robin_quantum_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_unit
// Time-stepped round-robin scheduler with a programmable time quantum.
// ----------------------------------------------------------------------------
// A load item (cmd 0) writes one task slot in the cycle it is accepted and
// gives no result; busy stays low. A tick item (cmd 1) keeps busy high while
// the slot table, which sits behind a single read port, is scanned one slot
// per cycle for arrivals and for remaining work; then five sequencer steps
// close the scan, requeue, dispatch and run one time unit (when every slot
// is already empty, only the step that closes the scan follows).
// The result is strobed on out_valid for exactly one cycle, the first cycle
// with busy low, and the receiver cannot stall it; a new item may be
// accepted in that same cycle. Slots at or above MAX_TASKS are ignored by
// loads. The slot table is cleared by reset through per-slot valid bits.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rrqs_pkg::rrqs_in_t in_data,
  output logic               out_valid,
  output rrqs_pkg::rrqs_out_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import rrqs_pkg::*;

  localparam int SW = $clog2(MAX_TASKS);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_RDCUR  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_RDRUN  = 3'd5;
  localparam logic [2:0] S_RUN    = 3'd6;

  // slot table
  logic [7:0]           id_mem  [MAX_TASKS];
  logic [15:0]          arr_mem [MAX_TASKS];
  logic [15:0]          rem_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_r, vld_nxt;

  logic [SW-1:0] tbl_addr;
  logic [7:0]    id_rd_r;
  logic [15:0]   arr_rd_r, rem_rd_r;
  logic          vld_rd_r;
  logic [7:0]    eff_id;
  logic [15:0]   eff_arr, eff_rem;

  logic          tbl_we;
  logic [SW-1:0] tbl_waddr;
  logic [7:0]    id_wdata;
  logic [15:0]   arr_wdata, rem_wdata;

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          chk_r, chk_nxt;
  logic          any_r, any_nxt;
  logic [15:0]   now_r, now_nxt;
  logic          cpu_busy_r, cpu_busy_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [15:0]   slice_r, slice_nxt;
  logic [15:0]   quantum_r;
  logic          out_valid_r, out_valid_nxt;
  rrqs_out_t     out_data_r, out_data_nxt;

  // ready queue interface
  logic          q_push, q_pop;
  logic [SW-1:0] q_push_data, q_head;
  rrqs_qstat_t   q_stat;

  logic          accept;
  logic [SW-1:0] ld_slot;
  logic          ld_in_range;
  logic          arrive;
  logic          any_now;
  logic          resched, keep;

  assign accept      = start && !busy;
  assign ld_slot     = SW'(in_data.slot);
  assign ld_in_range = (int'(in_data.slot) < MAX_TASKS);

  // entries never written read as an empty slot
  assign eff_id  = vld_rd_r ? id_rd_r  : 8'd0;
  assign eff_arr = vld_rd_r ? arr_rd_r : 16'd0;
  assign eff_rem = vld_rd_r ? rem_rd_r : 16'd0;

  // scan evaluation works on the registered read of the previous scan address
  assign arrive  = chk_r && (eff_arr == now_r) && (eff_rem != 16'd0);
  assign any_now = any_r || (chk_r && (eff_rem != 16'd0));

  assign resched = !cpu_busy_r || (slice_r == quantum_r);
  assign keep    = cpu_busy_r && (eff_rem != 16'd0);

  assign tbl_addr = (state_r == S_SCAN) ? idx_r : cur_r;

  rrqs_ready_fifo #(
    .DEPTH (MAX_TASKS)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .stat      (q_stat)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    chk_nxt       = (state_r == S_SCAN);
    any_nxt       = any_r;
    now_nxt       = now_r;
    cpu_busy_nxt  = cpu_busy_r;
    cur_nxt       = cur_r;
    slice_nxt     = slice_r;
    vld_nxt       = vld_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    q_push        = 1'b0;
    q_push_data   = idx_r;
    q_pop         = 1'b0;
    tbl_we        = 1'b0;
    tbl_waddr     = ld_slot;
    id_wdata      = in_data.task_id;
    arr_wdata     = in_data.arrival;
    rem_wdata     = in_data.burst;

    // arrivals found by the scan join the queue in slot order
    if (state_r == S_SCAN || state_r == S_DRAIN) begin
      any_nxt     = any_now;
      q_push      = arrive;
      q_push_data = SW'(idx_r - SW'(1));
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_LOAD) begin
            if (ld_in_range) begin
              tbl_we           = 1'b1;
              vld_nxt[ld_slot] = 1'b1;
            end
          end else begin
            idx_nxt   = '0;
            any_nxt   = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + SW'(1);
        if (idx_r == SW'(MAX_TASKS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        q_push_data = SW'(MAX_TASKS - 1);
        if (!any_now) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_DONE, running_id: 8'd0, completed: 1'b0,
                            finish_tick: 16'd0};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_RDCUR;
        end
      end
      S_RDCUR: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        // requeue behind new arrivals and dispatch the head
        if (resched) begin
          if (!q_stat.empty) begin
            q_pop        = 1'b1;
            q_push       = keep;
            q_push_data  = cur_r;
            cur_nxt      = q_head;
            cpu_busy_nxt = 1'b1;
          end else if (!keep) begin
            cpu_busy_nxt = 1'b0;
          end
          slice_nxt = 16'd0;
        end
        state_nxt = S_RDRUN;
      end
      S_RDRUN: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        // execute one unit of the running task
        out_data_nxt = '{status: ST_IDLE, running_id: 8'd0, completed: 1'b0,
                         finish_tick: 16'd0};
        if (cpu_busy_r) begin
          if (eff_rem == 16'd0) begin
            cpu_busy_nxt = 1'b0;
            slice_nxt    = 16'd0;
          end else begin
            out_data_nxt.status     = ST_RAN;
            out_data_nxt.running_id = eff_id;
            tbl_we    = 1'b1;
            tbl_waddr = cur_r;
            id_wdata  = eff_id;
            arr_wdata = eff_arr;
            rem_wdata = eff_rem - 16'd1;
            slice_nxt = sat_inc16(slice_r);
            if (eff_rem == 16'd1) begin
              out_data_nxt.completed   = 1'b1;
              out_data_nxt.finish_tick = sat_inc16(now_r);
              cpu_busy_nxt = 1'b0;
              slice_nxt    = 16'd0;
            end
          end
        end
        now_nxt       = sat_inc16(now_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      chk_r       <= 1'b0;
      any_r       <= 1'b0;
      now_r       <= 16'd0;
      cpu_busy_r  <= 1'b0;
      cur_r       <= '0;
      slice_r     <= 16'd0;
      vld_r       <= '0;
      vld_rd_r    <= 1'b0;
      out_valid_r <= 1'b0;
      quantum_r   <= QUANTUM_RST;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      chk_r       <= chk_nxt;
      any_r       <= any_nxt;
      now_r       <= now_nxt;
      cpu_busy_r  <= cpu_busy_nxt;
      cur_r       <= cur_nxt;
      slice_r     <= slice_nxt;
      vld_r       <= vld_nxt;
      vld_rd_r    <= vld_r[tbl_addr];
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
    end
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      id_mem[tbl_waddr]  <= id_wdata;
      arr_mem[tbl_waddr] <= arr_wdata;
      rem_mem[tbl_waddr] <= rem_wdata;
    end
    id_rd_r  <= id_mem[tbl_addr];
    arr_rd_r <= arr_mem[tbl_addr];
    rem_rd_r <= rem_mem[tbl_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result only follows the end of a tick
  a_result_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_RUN || $past(state_r) == S_DRAIN))
    else $error("result strobe without a finished tick");

  // a load never occupies the block
  a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.cmd == CMD_LOAD) |=> !busy)
    else $error("load item left the block busy");

  // completion only comes with a task that ran
  a_completed_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.completed) |-> (out_data.status == ST_RAN))
    else $error("completion flagged on a tick where no task ran");

  // all-finished report carries no task
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_DONE) |->
      (out_data.running_id == 8'd0 && !out_data.completed))
    else $error("all-finished result carries task fields");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for round_robin_quantum_scheduler_unit.
// ----------------------------------------------------------------------------
// Load and tick items are sent through the start/busy handshake. Each item is
// also applied to a cycle-free scheduler model kept here, and each tick queues
// the report the block must strobe. A monitor compares every strobed report,
// field by field, against the oldest queued one. Directed cases come first:
// the empty table, rotation, and reloads of queued or running slots. Random
// batches follow under several quantum values (1, max, 0 and a mid value),
// then a burst of arrivals and requeues that overfills the ready queue.
// ----------------------------------------------------------------------------
module testbench;
  import rrqs_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int DRAIN_CYCLES = 30;    // covers one tick scan plus the strobe
  localparam int STALL_LIMIT  = 2000;  // cycles without any accepted item
  localparam int GAP_MAX      = 18;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  rrqs_in_t    in_data;
  logic        out_valid;
  rrqs_out_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  // scheduler model state
  logic [7:0]  tk_id[NUM_SLOTS];
  logic [15:0] tk_arrival[NUM_SLOTS];
  logic [15:0] tk_left[NUM_SLOTS];
  logic [3:0]  rq_slot[NUM_SLOTS];
  int          rq_head;
  int          rq_count;
  logic [15:0] clock_now;
  bit          cpu_on;
  logic [3:0]  cpu_slot;
  logic [15:0] slice_cnt;
  logic [15:0] quantum_val;

  // reports still owed by the block, oldest first
  rrqs_out_t   reports_due[$];
  rrqs_out_t   want;

  int          n_loads;
  int          n_ticks;
  int          n_settings;
  int          checked;
  int          mismatches;
  int          idle_cycles;

  round_robin_quantum_scheduler_unit #(
    .MAX_TASKS(NUM_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // scheduler model
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == TIME_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] time_ahead(input int k);
    int t;
    t = int'(clock_now) + k;
    return (t > 65535) ? TIME_MAX : t[15:0];
  endfunction

  function automatic bit work_left();
    int s;
    for (s = 0; s < NUM_SLOTS; s++)
      if (tk_left[s] != 16'd0) return 1'b1;
    return 1'b0;
  endfunction

  // full queue drops the push
  function automatic void rq_push(input logic [3:0] s);
    if (rq_count < NUM_SLOTS) begin
      rq_slot[(rq_head + rq_count) % NUM_SLOTS] = s;
      rq_count++;
    end
  endfunction

  function automatic logic [3:0] rq_pop();
    logic [3:0] s;
    s = rq_slot[rq_head];
    rq_head = (rq_head + 1) % NUM_SLOTS;
    rq_count--;
    return s;
  endfunction

  // applies one item; returns 1 when it yields a report
  function automatic bit schedule_step(input rrqs_in_t it, output rrqs_out_t rep);
    int         s;
    bit         keep;
    logic [3:0] nxt;
    rep = '0;
    if (it.cmd == CMD_LOAD) begin
      tk_id[it.slot]      = it.task_id;
      tk_arrival[it.slot] = it.arrival;
      tk_left[it.slot]    = it.burst;
      return 1'b0;
    end
    rep.status = ST_IDLE;
    if (!work_left()) begin
      rep.status = ST_DONE;
      return 1'b1;
    end
    // arrivals join in slot order
    for (s = 0; s < NUM_SLOTS; s++)
      if (tk_arrival[s] == clock_now && tk_left[s] != 16'd0) rq_push(s[3:0]);
    // dispatch on idle CPU or expired slice
    if (!cpu_on || slice_cnt == quantum_val) begin
      keep = cpu_on && tk_left[cpu_slot] != 16'd0;
      if (rq_count != 0) begin
        nxt = rq_pop();
        if (keep) rq_push(cpu_slot);
        cpu_slot = nxt;
        cpu_on   = 1'b1;
      end else if (!keep) begin
        cpu_on = 1'b0;
      end
      slice_cnt = 16'd0;
    end
    // run one unit
    if (cpu_on) begin
      if (tk_left[cpu_slot] == 16'd0) begin
        cpu_on    = 1'b0;
        slice_cnt = 16'd0;
      end else begin
        rep.status     = ST_RAN;
        rep.running_id = tk_id[cpu_slot];
        tk_left[cpu_slot] = tk_left[cpu_slot] - 16'd1;
        slice_cnt = bump16(slice_cnt);
        if (tk_left[cpu_slot] == 16'd0) begin
          rep.completed   = 1'b1;
          rep.finish_tick = bump16(clock_now);
          cpu_on    = 1'b0;
          slice_cnt = 16'd0;
        end
      end
    end
    clock_now = bump16(clock_now);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(input bit no_gaps);
    return no_gaps ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic rrqs_in_t make_load(input logic [3:0] s, input logic [7:0] id,
                                         input logic [15:0] arr, input logic [15:0] b);
    rrqs_in_t it;
    it.cmd     = CMD_LOAD;
    it.slot    = s;
    it.task_id = id;
    it.arrival = arr;
    it.burst   = b;
    return it;
  endfunction

  // tick payload bits other than cmd are don't-care and get random values
  function automatic rrqs_in_t make_tick();
    rrqs_in_t    it;
    logic [63:0] r;
    r      = {$urandom, $urandom};
    it     = r[$bits(rrqs_in_t)-1:0];
    it.cmd = CMD_TICK;
    return it;
  endfunction

  // sends one item after a gap; start is left high on return
  task automatic send_item(input rrqs_in_t it, input int gap);
    rrqs_out_t rep;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    if (it.cmd == CMD_LOAD) n_loads++;
    else n_ticks++;
    if (schedule_step(it, rep)) reports_due.push_back(rep);
  endtask

  // waits for every owed report, then lets the block go quiet
  task automatic settle();
    start <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_quantum(input logic [15:0] q);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we      <= 1'b0;
    quantum_val = q;
    n_settings++;
  endtask

  // ticks while work remains, optionally reloading slots mid-run, then one more
  task automatic run_until_done(input int cap, input bit stir, input bit no_gaps);
    int n;
    n = 0;
    while (work_left() && n < cap) begin
      if (stir && $urandom_range(0, 9) == 0)
        send_item(make_load(4'($urandom_range(0, 15)), 8'($urandom),
                            time_ahead($urandom_range(0, 3)),
                            16'($urandom_range(0, 4))), pick_gap(no_gaps));
      send_item(make_tick(), pick_gap(no_gaps));
      n++;
    end
    send_item(make_tick(), pick_gap(no_gaps));
  endtask

  // empties every slot that still holds work
  task automatic clear_leftovers(input bit no_gaps);
    int s;
    for (s = 0; s < NUM_SLOTS; s++)
      if (tk_left[s] != 16'd0)
        send_item(make_load(s[3:0], 8'($urandom), 16'($urandom), 16'd0),
                  pick_gap(no_gaps));
  endtask

  // one well-formed batch: a few tasks arriving soon, run to completion
  task automatic run_batch(input bit no_gaps);
    int          n;
    logic [15:0] b;
    logic [15:0] arr;
    n = $urandom_range(1, 6);
    repeat (n) begin
      b   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(6, 40))
                                        : 16'($urandom_range(1, 5));
      arr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : time_ahead($urandom_range(0, 6));
      send_item(make_load(4'($urandom_range(0, 15)), 8'($urandom), arr, b),
                pick_gap(no_gaps));
    end
    // noise: a load with every field random
    if ($urandom_range(0, 3) == 0)
      send_item(make_load(4'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)),
                pick_gap(no_gaps));
    run_until_done(40, 1'b1, no_gaps);
    clear_leftovers(no_gaps);
    send_item(make_tick(), pick_gap(no_gaps));
  endtask

  task automatic run_random_phase(input int target);
    int first;
    first = n_loads + n_ticks;
    while (n_loads + n_ticks - first < target) begin
      run_batch($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 7) == 0) settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // empty table and zero-burst slots report all finished without advancing time
  task automatic test_empty_table();
    send_item(make_tick(), 0);
    send_item(make_load(4'd4, 8'h99, 16'd0, 16'd0), 1);
    send_item(make_tick(), 0);
  endtask

  // rotation at reset quantum, reload of a queued slot and of the running slot
  task automatic test_rotation_and_reload();
    send_item(make_load(4'd0, 8'hFF, 16'd0, 16'd3), 0);
    send_item(make_load(4'd15, 8'h00, 16'd1, 16'd2), 2);
    send_item(make_load(4'd9, 8'h80, 16'd1, 16'd1), 0);
    repeat (3) send_item(make_tick(), $urandom_range(0, 3));
    send_item(make_load(4'd15, 8'h42, 16'd1, 16'd0), 0);
    run_until_done(20, 1'b0, 1'b1);
    // running task emptied underneath: idle tick, CPU freed
    send_item(make_load(4'd2, 8'h02, time_ahead(0), 16'd5), 0);
    send_item(make_load(4'd3, 8'h03, time_ahead(0), 16'd2), 0);
    repeat (2) send_item(make_tick(), 0);
    send_item(make_load(4'd2, 8'h02, time_ahead(0), 16'd0), 0);
    run_until_done(20, 1'b0, 1'b0);
  endtask

  // random traffic under extreme and ordinary quantum values
  task automatic test_quantum_sweep();
    set_quantum(16'd1);
    run_random_phase(75);
    set_quantum(16'hFFFF);
    run_random_phase(75);
    set_quantum(16'd0);
    run_random_phase(75);
    set_quantum(16'($urandom_range(2, 9)));
    run_random_phase(75);
  endtask

  // every slot arrives at once, then the waiting ones are requeued again:
  // the ready queue fills and later arrivals are dropped
  task automatic test_queue_overflow();
    int s;
    set_quantum(16'd2);
    for (s = 0; s < NUM_SLOTS; s++)
      send_item(make_load(s[3:0], 8'(s + 1), clock_now, 16'd3), pick_gap(1'b0));
    send_item(make_tick(), 0);
    for (s = 1; s < NUM_SLOTS; s++)
      send_item(make_load(s[3:0], 8'(s + 17), clock_now, 16'd2), 0);
    run_until_done(120, 1'b0, 1'b0);
    clear_leftovers(1'b0);
    send_item(make_tick(), 0);
  endtask

  // ---------------------------------------------------------------------------
  // report monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: status %0d id %0d done %0d finish %0d",
                   out_data.status, out_data.running_id, out_data.completed,
                   out_data.finish_tick);
      end else begin
        want = reports_due.pop_front();
        checked++;
        if (out_data.status !== want.status || out_data.running_id !== want.running_id ||
            out_data.completed !== want.completed ||
            out_data.finish_tick !== want.finish_tick) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch at %0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $realtime, want.status, want.running_id, want.completed,
                     want.finish_tick, out_data.status, out_data.running_id,
                     out_data.completed, out_data.finish_tick);
        end
      end
    end
  end

  // watchdog on input handshake progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    n_loads     = 0;
    n_ticks     = 0;
    n_settings  = 0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      tk_id[s]      = '0;
      tk_arrival[s] = '0;
      tk_left[s]    = '0;
      rq_slot[s]    = '0;
    end
    rq_head     = 0;
    rq_count    = 0;
    clock_now   = '0;
    cpu_on      = 1'b0;
    cpu_slot    = '0;
    slice_cnt   = '0;
    quantum_val = QUANTUM_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_rotation_and_reload();
    test_quantum_sweep();
    test_queue_overflow();
    settle();

    $display("Sent %0d loads and %0d ticks across %0d quantum values, incl. queue overflow.",
             n_loads, n_ticks, n_settings);
    $display("Checked %0d tick reports, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rrqs_pkg.sv
rtl/rrqs_ready_fifo.sv
rtl/round_robin_quantum_scheduler_unit.sv
tb/sv/testbench.sv
